[hdl/tsls_pkg.sv]
// ----------------------------------------------------------------------------
// tsls_pkg
// Shared widths, register map and reset values of the two-sphere level set.
// ----------------------------------------------------------------------------
package tsls_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int OUT_W    = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * COORD_W + 1;
  localparam int SUM_W    = SQ_W + 1;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int VAL_W    = ROOT_W + 1;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int DEF_COMBINE_MODE = 0;
  localparam int DEF_FRAC_BITS    = 16;

  typedef enum logic [2:0] {
    REG_FIRST_CX  = 3'd0,
    REG_FIRST_CY  = 3'd1,
    REG_FIRST_CZ  = 3'd2,
    REG_FIRST_R   = 3'd3,
    REG_SECOND_CX = 3'd4,
    REG_SECOND_CY = 3'd5,
    REG_SECOND_CZ = 3'd6,
    REG_SECOND_R  = 3'd7
  } reg_idx_e;

  localparam logic signed [COORD_W-1:0] RST_FIRST_CZ  = 24'sd154806;
  localparam logic signed [COORD_W-1:0] RST_SECOND_CZ = -24'sd154806;
  localparam logic [RADIUS_W-1:0]       RST_RADIUS    = 23'd65536;

endpackage

[hdl/two_sphere_level_set.sv]
// ----------------------------------------------------------------------------
// two_sphere_level_set
// Signed level-set value of two spheres combined by min, max or product.
// ----------------------------------------------------------------------------
// One point is taken per cycle unless the output stalls. The 25-stage square
// root pipeline, one root bit per stage, runs two spheres side by side. A
// stalled output holds the whole pipeline and the input stalls with it. The
// user writes sphere registers over the APB port only while no transaction
// is in flight; the block itself does not enforce it.
module two_sphere_level_set #(
  parameter int COMBINE_MODE = tsls_pkg::DEF_COMBINE_MODE,
  parameter int FRAC_BITS    = tsls_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsls_pkg::ADDR_W-1:0]           paddr,
  input  logic [tsls_pkg::DATA_W-1:0]           pwdata,
  output logic [tsls_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tsls_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [tsls_pkg::COORD_W-1:0]   point_y_i,
  input  logic signed [tsls_pkg::COORD_W-1:0]   point_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tsls_pkg::OUT_W-1:0]     level_value_o
);
  import tsls_pkg::*;

  localparam int  STEPS   = ROOT_W;
  localparam bit  IS_PROD = (COMBINE_MODE != 0) && (COMBINE_MODE != 1);

  // ---------------- configuration registers ----------------
  logic signed [COORD_W-1:0]  cx_q [2];
  logic signed [COORD_W-1:0]  cy_q [2];
  logic signed [COORD_W-1:0]  cz_q [2];
  logic        [RADIUS_W-1:0] rad_q [2];
  logic                       wr_en;
  reg_idx_e                   widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q[0]  <= '0;
      cy_q[0]  <= '0;
      cz_q[0]  <= RST_FIRST_CZ;
      rad_q[0] <= RST_RADIUS;
      cx_q[1]  <= '0;
      cy_q[1]  <= '0;
      cz_q[1]  <= RST_SECOND_CZ;
      rad_q[1] <= RST_RADIUS;
    end else if (wr_en) begin
      unique case (widx)
        REG_FIRST_CX:  cx_q[0]  <= pwdata[COORD_W-1:0];
        REG_FIRST_CY:  cy_q[0]  <= pwdata[COORD_W-1:0];
        REG_FIRST_CZ:  cz_q[0]  <= pwdata[COORD_W-1:0];
        REG_FIRST_R:   rad_q[0] <= pwdata[RADIUS_W-1:0];
        REG_SECOND_CX: cx_q[1]  <= pwdata[COORD_W-1:0];
        REG_SECOND_CY: cy_q[1]  <= pwdata[COORD_W-1:0];
        REG_SECOND_CZ: cz_q[1]  <= pwdata[COORD_W-1:0];
        REG_SECOND_R:  rad_q[1] <= pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_FIRST_CX:  prdata = DATA_W'(cx_q[0]);
      REG_FIRST_CY:  prdata = DATA_W'(cy_q[0]);
      REG_FIRST_CZ:  prdata = DATA_W'(cz_q[0]);
      REG_FIRST_R:   prdata = DATA_W'(rad_q[0]);
      REG_SECOND_CX: prdata = DATA_W'(cx_q[1]);
      REG_SECOND_CY: prdata = DATA_W'(cy_q[1]);
      REG_SECOND_CZ: prdata = DATA_W'(cz_q[1]);
      REG_SECOND_R:  prdata = DATA_W'(rad_q[1]);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: differences
  logic                     v1_q;
  logic signed [DIFF_W-1:0] dx_q [2], dy_q [2], dz_q [2];
  // stage 2: squares
  logic                     v2_q;
  logic        [SQ_W-1:0]   sx_q [2], sy_q [2], sz_q [2];
  // stage 3: sum of squares
  logic                     v3_q;
  logic        [SUM_W-1:0]  sum_q [2];
  // root stages
  logic                     vr_q   [STEPS];
  logic        [SUM_W-1:0]  rd_q   [STEPS][2];
  logic        [REM_W-1:0]  rem_q  [STEPS][2];
  logic        [ROOT_W-1:0] root_q [STEPS][2];
  // stage after root: sphere values
  logic                     v4_q;
  logic signed [VAL_W-1:0]  sv_q [2];
  // combine stage
  logic                     v5_q;
  logic signed [PROD_W-1:0] cmb_q;
  logic signed [OUT_W-1:0]  out_q;

  logic signed [DIFF_W-1:0] prod_dx [2], prod_dy [2], prod_dz [2];
  logic signed [2*DIFF_W-1:0] px2 [2], py2 [2], pz2 [2];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      prod_dx[s] = dx_q[s];
      prod_dy[s] = dy_q[s];
      prod_dz[s] = dz_q[s];
      px2[s] = prod_dx[s] * prod_dx[s];
      py2[s] = prod_dy[s] * prod_dy[s];
      pz2[s] = prod_dz[s] * prod_dz[s];
    end
  end

  // one root digit per stage from the top radicand pair
  logic [SUM_W-1:0]  st_rd   [STEPS][2];
  logic [REM_W-1:0]  st_rem  [STEPS][2];
  logic [ROOT_W-1:0] st_root [STEPS][2];
  logic [REM_W+1:0]  cur     [STEPS][2];
  logic [REM_W+1:0]  trial   [STEPS][2];
  logic [REM_W+1:0]  diff    [STEPS][2];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      for (int s = 0; s < 2; s++) begin
        if (k == 0) begin
          st_rd[k][s]   = sum_q[s];
          st_rem[k][s]  = '0;
          st_root[k][s] = '0;
        end else begin
          st_rd[k][s]   = rd_q[k-1][s];
          st_rem[k][s]  = rem_q[k-1][s];
          st_root[k][s] = root_q[k-1][s];
        end
        cur[k][s]   = {st_rem[k][s], st_rd[k][s][SUM_W-1 -: 2]};
        trial[k][s] = (REM_W+2)'({st_root[k][s], 2'b01});
        diff[k][s]  = cur[k][s] - trial[k][s];
      end
    end
  end

  logic signed [VAL_W-1:0]  a_v, b_v;
  logic signed [PROD_W-1:0] cmb_d;
  logic signed [PROD_W-1:0] shf;
  logic signed [OUT_W-1:0]  sat_d;

  always_comb begin
    a_v = sv_q[0];
    b_v = sv_q[1];
    if (IS_PROD) begin
      cmb_d = a_v * b_v;
    end else if (COMBINE_MODE == 0) begin
      cmb_d = PROD_W'((a_v < b_v) ? a_v : b_v);
    end else begin
      cmb_d = PROD_W'((a_v > b_v) ? a_v : b_v);
    end
    shf = IS_PROD ? (cmb_q >>> FRAC_BITS) : cmb_q;
    priority if (shf > PROD_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      sat_d = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (shf < -PROD_W'(signed'({1'b0, {(OUT_W-1){1'b1}}})) - 1) begin
      sat_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_d = shf[OUT_W-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < STEPS; k++) vr_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vr_q[0] <= v3_q;
      for (int k = 1; k < STEPS; k++) vr_q[k] <= vr_q[k-1];
      v4_q        <= vr_q[STEPS-1];
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        dx_q[s]  <= DIFF_W'(point_x_i) - DIFF_W'(cx_q[s]);
        dy_q[s]  <= DIFF_W'(point_y_i) - DIFF_W'(cy_q[s]);
        dz_q[s]  <= DIFF_W'(point_z_i) - DIFF_W'(cz_q[s]);
        sx_q[s]  <= px2[s][SQ_W-1:0];
        sy_q[s]  <= py2[s][SQ_W-1:0];
        sz_q[s]  <= pz2[s][SQ_W-1:0];
        sum_q[s] <= SUM_W'(sx_q[s]) + SUM_W'(sy_q[s]) + SUM_W'(sz_q[s]);
        for (int k = 0; k < STEPS; k++) begin
          rd_q[k][s] <= {st_rd[k][s][SUM_W-3:0], 2'b00};
          if (!diff[k][s][REM_W+1]) begin
            rem_q[k][s]  <= diff[k][s][REM_W-1:0];
            root_q[k][s] <= {st_root[k][s][ROOT_W-2:0], 1'b1};
          end else begin
            rem_q[k][s]  <= cur[k][s][REM_W-1:0];
            root_q[k][s] <= {st_root[k][s][ROOT_W-2:0], 1'b0};
          end
        end
        sv_q[s] <= signed'({1'b0, root_q[STEPS-1][s]}) - signed'(VAL_W'(rad_q[s]));
      end
      cmb_q <= cmb_d;
      out_q <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_value_o = out_q;

endmodule

[hdl/tsls_checker.sv]
// ----------------------------------------------------------------------------
// tsls_checker
// Port-level checks of the two-sphere level set, bound to the top level.
// ----------------------------------------------------------------------------
module tsls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] level_value_o,
  input logic        pready
);

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(level_value_o)))
    else $error("stalled result changed");

  // the input stalls exactly when a result is held
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  // no result right after reset release
  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind two_sphere_level_set tsls_checker u_tsls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .level_value_o (level_value_o),
  .pready        (pready)
);
